// ----- hw/rtl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue with search.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_ITEM_WIDTH  = 32;
   localparam int VALUE_WIDTH         = 32;
   localparam int COUNT_OUT_WIDTH     = 5;
   localparam int FUNC_WIDTH          = 3;
   localparam int STATUS_WIDTH        = 2;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_REMOVE     = 3'd4,
      FUNC_FIND       = 3'd5,
      FUNC_LIST       = 3'd6,
      FUNC_NOP        = 3'd7
   } func_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NO_MATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_APPEND,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic first;
      logic tail;
      logic append;
   } cell_pos_type;

endpackage
`default_nettype wire

// ----- hw/rtl/deq_ifs.sv -----
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface deq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] item_value;

   modport source (output valid, output func, output item_value, input ready);
   modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface deq_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        result_valid;
   logic [1:0]  status;
   logic        last_of_run;
   logic [4:0]  entry_count;
   logic [31:0] front_value;
   logic [31:0] back_value;

   modport source (output valid, output result_value, output result_valid, output status,
                   output last_of_run, output entry_count, output front_value,
                   output back_value, input ready);
   modport sink   (input valid, input result_value, input result_valid, input status,
                   input last_of_run, input entry_count, input front_value,
                   input back_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/deq_cell.sv -----
// One storage cell of the queue chain.
`timescale 1ns / 1ps
`default_nettype none
module deq_cell
   import deq_pkg::*;
#(
   parameter int ITEM_WIDTH = DEFAULT_ITEM_WIDTH
) (
   input  wire logic                  clock,
   input  wire cell_op_type           op,
   input  wire cell_pos_type          pos,
   input  wire logic [ITEM_WIDTH-1:0] item,
   input  wire logic [ITEM_WIDTH-1:0] head_data,
   input  wire logic [ITEM_WIDTH-1:0] prev_data,
   input  wire logic [ITEM_WIDTH-1:0] next_data,
   output logic      [ITEM_WIDTH-1:0] data
);

   logic [ITEM_WIDTH-1:0] data_ff;
   logic [ITEM_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (op)
         CELL_HOLD:       data_in = data_ff;
         CELL_PUSH_FRONT: data_in = pos.first ? item : prev_data;
         CELL_APPEND:     data_in = pos.append ? item : data_ff;
         CELL_SHIFT:      data_in = next_data;
         CELL_ROTATE:     data_in = pos.tail ? head_data : next_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/double_ended_queue_with_search_core.sv -----
// Top level: deque built as a chain of cells with a scan controller.
// Push, pop and no-op: answered from ST_REPORT; no new request is taken until it is sent.
// Find and remove: the chain steps once per held entry, then ST_REPORT sends the result.
// List: results come from ST_SCAN, one result per cycle while the sink takes them.
// Rate is set by the single rotation of the cell chain per cycle; a list holds on a sink stall.
// Reset clears count, controller state and output valid, and sets the compare mask to all ones.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_with_search_core
   import deq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int ITEM_WIDTH  = DEFAULT_ITEM_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   deq_req_if.sink                     req_chan,
   deq_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [VALUE_WIDTH-1:0] csr_wr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           step_ff, step_in;
   logic [CW-1:0]           len_ff, len_in;
   logic                    found_ff, found_in;
   func_type                func_ff, func_in;
   logic [ITEM_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0]  mask_ff, mask_in;
   logic [VALUE_WIDTH-1:0]  res_val_ff, res_val_in;
   logic                    res_valid_ff, res_valid_in;
   status_type              status_ff, status_in;
   logic [VALUE_WIDTH-1:0]  front_cap_ff, front_cap_in;
   logic [VALUE_WIDTH-1:0]  back_cap_ff, back_cap_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]     rsp_value_ff, rsp_value_in;
   logic                       rsp_rvalid_ff, rsp_rvalid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [COUNT_OUT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [VALUE_WIDTH-1:0]     rsp_front_ff, rsp_front_in;
   logic [VALUE_WIDTH-1:0]     rsp_back_ff, rsp_back_in;

   cell_op_type             cell_op;
   logic [ITEM_WIDTH-1:0]   cell_data [QUEUE_DEPTH];
   logic [ITEM_WIDTH-1:0]   head_data;
   logic [ITEM_WIDTH-1:0]   tail_data;
   logic [ITEM_WIDTH-1:0]   req_item;
   logic [ITEM_WIDTH+31:0]  req_ext;
   logic [ITEM_WIDTH+31:0]  head_ext;
   logic [ITEM_WIDTH+31:0]  tail_ext;
   logic [ITEM_WIDTH+31:0]  diff_ext;
   logic [CW+31:0]          count_ext;
   logic [VALUE_WIDTH-1:0]  head32;
   logic [VALUE_WIDTH-1:0]  tail32;
   logic [CW-1:0]           count_m1;
   logic [IW-1:0]           tail_idx;
   logic [CW-1:0]           step_nx;
   logic                    head_match;
   logic                    out_free;
   logic                    req_fire;
   logic                    is_empty;
   logic                    is_full;

   // Cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_pos_type          pos;
      logic [ITEM_WIDTH-1:0] prev_data;
      logic [ITEM_WIDTH-1:0] next_data;

      assign pos.first  = (i == 0);
      assign pos.tail   = (tail_idx == IW'(i));
      assign pos.append = (count_ff == CW'(i));

      if (i == 0) begin : g_first
         assign prev_data = cell_data[0];
      end else begin : g_prev
         assign prev_data = cell_data[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_data = cell_data[QUEUE_DEPTH-1];
      end else begin : g_next
         assign next_data = cell_data[i+1];
      end

      deq_cell #(
         .ITEM_WIDTH(ITEM_WIDTH)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .pos       (pos),
         .item      (req_item),
         .head_data (head_data),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   assign count_m1  = count_ff - 1'b1;
   assign tail_idx  = count_m1[IW-1:0];
   assign head_data = cell_data[0];
   assign tail_data = cell_data[tail_idx];

   assign req_ext   = {{ITEM_WIDTH{1'b0}}, req_chan.item_value};
   assign req_item  = req_ext[ITEM_WIDTH-1:0];
   assign head_ext  = {32'd0, head_data};
   assign tail_ext  = {32'd0, tail_data};
   assign diff_ext  = {32'd0, head_data ^ key_ff};
   assign count_ext = {32'd0, count_ff};
   assign head32    = head_ext[VALUE_WIDTH-1:0];
   assign tail32    = tail_ext[VALUE_WIDTH-1:0];

   assign head_match = ((diff_ext[VALUE_WIDTH-1:0] & mask_ff) == '0);
   assign step_nx    = step_ff + 1'b1;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CW'(QUEUE_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      len_in        = len_ff;
      found_in      = found_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      mask_in       = csr_wr_en ? csr_wr_data : mask_ff;
      res_val_in    = res_val_ff;
      res_valid_in  = res_valid_ff;
      status_in     = status_ff;
      front_cap_in  = front_cap_ff;
      back_cap_in   = back_cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      cell_op       = CELL_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in      = func_type'(req_chan.func);
               key_in       = req_item;
               res_val_in   = '0;
               res_valid_in = 1'b0;
               status_in    = STATUS_OK;
               step_in      = '0;
               len_in       = count_ff;
               found_in     = 1'b0;
               front_cap_in = head32;
               back_cap_in  = tail32;
               state_in     = ST_REPORT;
               unique case (func_type'(req_chan.func))
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cell_op  = (func_type'(req_chan.func) == FUNC_PUSH_FRONT) ?
                                   CELL_PUSH_FRONT : CELL_APPEND;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_POP_FRONT, FUNC_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        res_valid_in = 1'b1;
                        count_in     = count_m1;
                        if (func_type'(req_chan.func) == FUNC_POP_FRONT) begin
                           res_val_in = head32;
                           cell_op    = CELL_SHIFT;
                        end else begin
                           res_val_in = tail32;
                        end
                     end
                  end
                  FUNC_REMOVE, FUNC_FIND, FUNC_LIST: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (func_ff == FUNC_LIST) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = head32;
                  rsp_rvalid_in = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_last_in   = (step_nx == len_ff);
                  rsp_count_in  = count_ext[COUNT_OUT_WIDTH-1:0];
                  rsp_front_in  = front_cap_ff;
                  rsp_back_in   = back_cap_ff;
                  cell_op       = CELL_ROTATE;
                  step_in       = step_nx;
                  if (step_nx == len_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               step_in = step_nx;
               cell_op = CELL_ROTATE;
               if (!found_ff && head_match) begin
                  found_in     = 1'b1;
                  res_val_in   = head32;
                  res_valid_in = 1'b1;
                  if (func_ff == FUNC_REMOVE) begin
                     cell_op  = CELL_SHIFT;
                     count_in = count_m1;
                  end
               end
               if (step_nx == len_ff) begin
                  state_in  = ST_REPORT;
                  status_in = (found_ff || head_match) ? STATUS_OK : STATUS_NO_MATCH;
               end
            end
         end

         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_val_ff;
               rsp_rvalid_in = res_valid_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               rsp_count_in  = count_ext[COUNT_OUT_WIDTH-1:0];
               rsp_front_in  = is_empty ? '0 : head32;
               rsp_back_in   = is_empty ? '0 : tail32;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mask_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      len_ff        <= len_in;
      found_ff      <= found_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      res_val_ff    <= res_val_in;
      res_valid_ff  <= res_valid_in;
      status_ff     <= status_in;
      front_cap_ff  <= front_cap_in;
      back_cap_ff   <= back_cap_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.result_valid = rsp_rvalid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.last_of_run  = rsp_last_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;
   assign rsp_chan.front_value  = rsp_front_ff;
   assign rsp_chan.back_value   = rsp_back_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds depth");

   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff < len_ff) && (len_ff != '0))
      else $error("scan step out of range");

   a_count_delta: assert property (@(posedge clock) disable iff (reset)
      ##1 ((count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) ||
           (count_ff == $past(count_ff) - 1'b1)))
      else $error("entry count jumped");

   a_list_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && func_ff == FUNC_LIST) |=> $stable(count_ff))
      else $error("entry count changed during list");

   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (state_ff != ST_IDLE) || !$past(found_ff) ||
      ($past(func_ff) != FUNC_LIST))
      else $error("scan left early");
`endif

endmodule
`default_nettype wire
